// ===== sv/tga_rle_pkg.sv =====
`timescale 1ns / 1ps

package tga_rle_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int PIXEL_W  = 32;
    localparam int REPEAT_W = 8;
    localparam int COUNT_W  = 25;
    localparam int M_DATA_W = PIXEL_W + REPEAT_W;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = COUNT_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TEXEL_BYTES     = 2'd0,
        CFG_COMPRESSED_MODE = 2'd1,
        CFG_IMAGE_PIXELS    = 2'd2
    } cfg_index_t;

    // packet header fields
    localparam logic [BYTE_W-1:0] HDR_COUNT_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] HDR_RUN_MASK   = 8'h80;

    // texel sizes
    localparam logic [2:0] TEXEL_BYTES_BGRA = 3'd4;

    // largest repeat of one packet
    localparam logic [REPEAT_W-1:0] REPEAT_MAX = 8'd128;

endpackage

// ===== sv/tga_rle_pixel_decoder_unit.sv =====
`timescale 1ns / 1ps

// TGA run-length pixel decoder
//
// s_tdata carries the image body one byte per item, starting right after the
// file header. In compressed mode packet headers are consumed without output;
// a run packet gives one item (texel plus repeat count), a raw packet gives one
// item per texel with repeat 1. In uncompressed mode every texel gives an item.
// m_tlast marks the item that completes the image, m_tuser a packet cut short at
// the image end. The user must write the config port only while idle; not enforced.
//
// An accepted byte waits in the input register; its result, if any, goes into
// the output register once that is free. One byte is taken per cycle while the
// receiver does not stall, with a single decode stage between input and output
// register.
// Reset empties both registers and re-arms for a packet header and a new image.
// When the receiver stalls, the held result stays in the output register, one
// more byte waits in the input register, and s_tready then drops.
module tga_rle_pixel_decoder_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [tga_rle_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // byte input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tga_rle_pkg::BYTE_W-1:0]       s_tdata,   // in_byte
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tga_rle_pkg::M_DATA_W-1:0]     m_tdata,   // pixel_value, repeat_count
    output logic                                 m_tlast,   // image_end
    output logic                                 m_tuser    // overrun
);

    localparam int BW = tga_rle_pkg::BYTE_W;
    localparam int PW = tga_rle_pkg::PIXEL_W;
    localparam int RW = tga_rle_pkg::REPEAT_W;
    localparam int CW = tga_rle_pkg::COUNT_W;

    // configuration registers
    logic [2:0]    texel_bytes_reg;
    logic          compressed_mode_reg;
    logic [CW-1:0] image_pixels_reg;

    // input register
    logic          in_valid_reg;
    logic [BW-1:0] in_byte_reg;

    // decoder state
    logic          expect_header_reg, expect_header_next;
    logic          packet_is_run_reg, packet_is_run_next;
    logic [RW-1:0] packet_left_reg, packet_left_next;
    logic [1:0]    byte_position_reg, byte_position_next;
    logic [PW-1:0] texel_gather_reg, texel_gather_next;
    logic [CW-1:0] pixels_left_reg, pixels_left_next;

    // output register
    logic          out_valid_reg;
    logic [PW-1:0] out_pixel_reg;
    logic [RW-1:0] out_repeat_reg;
    logic          out_end_reg;
    logic          out_over_reg;

    // decode results
    logic          fire;
    logic          emit;
    logic [PW-1:0] gathered;
    logic          texel_done;
    logic [CW-1:0] pixels_eff;
    logic [RW-1:0] rep;
    logic          over;
    logic [RW-1:0] raw_left;

    // handshake
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texel_bytes_reg     <= tga_rle_pkg::TEXEL_BYTES_BGRA;
            compressed_mode_reg <= 1'b1;
            image_pixels_reg    <= CW'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tga_rle_pkg::CFG_TEXEL_BYTES:     texel_bytes_reg     <= cfg_wdata[2:0];
                tga_rle_pkg::CFG_COMPRESSED_MODE: compressed_mode_reg <= cfg_wdata[0];
                tga_rle_pkg::CFG_IMAGE_PIXELS:    image_pixels_reg    <= cfg_wdata;
                default:                          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // byte gathering and packet decode
    always_comb
    begin
        expect_header_next = expect_header_reg;
        packet_is_run_next = packet_is_run_reg;
        packet_left_next   = packet_left_reg;
        byte_position_next = byte_position_reg;
        texel_gather_next  = texel_gather_reg;
        pixels_left_next   = pixels_left_reg;
        emit               = 1'b0;
        rep                = RW'(1);
        over               = 1'b0;
        raw_left           = packet_left_reg - RW'(1);

        gathered   = texel_gather_reg | (PW'(in_byte_reg) << {byte_position_reg, 3'b000});
        texel_done = (texel_bytes_reg == tga_rle_pkg::TEXEL_BYTES_BGRA) ?
                     (byte_position_reg == 2'd3) : (byte_position_reg >= 2'd2);
        if (pixels_left_reg != '0)
            pixels_eff = pixels_left_reg;
        else if (image_pixels_reg == '0)
            pixels_eff = CW'(1);
        else
            pixels_eff = image_pixels_reg;

        if (compressed_mode_reg && expect_header_reg)
        begin
            // packet header
            packet_left_next   = (in_byte_reg & tga_rle_pkg::HDR_COUNT_MASK) + RW'(1);
            packet_is_run_next = (in_byte_reg & tga_rle_pkg::HDR_RUN_MASK) != '0;
            expect_header_next = 1'b0;
            byte_position_next = '0;
            texel_gather_next  = '0;
        end
        else if (!texel_done)
        begin
            texel_gather_next  = gathered;
            byte_position_next = byte_position_reg + 2'd1;
        end
        else
        begin
            emit               = 1'b1;
            texel_gather_next  = '0;
            byte_position_next = '0;
            if (compressed_mode_reg)
            begin
                if (packet_is_run_reg)
                begin
                    // run packet, clamped at the image end
                    rep = packet_left_reg;
                    if (CW'(packet_left_reg) > pixels_eff)
                    begin
                        rep  = pixels_eff[RW-1:0];
                        over = 1'b1;
                    end
                    packet_left_next   = '0;
                    expect_header_next = 1'b1;
                end
                else
                begin
                    // raw packet, rest dropped at the image end
                    packet_left_next = raw_left;
                    if (raw_left == '0)
                        expect_header_next = 1'b1;
                    if (pixels_eff == CW'(1) && raw_left != '0)
                    begin
                        over               = 1'b1;
                        packet_left_next   = '0;
                        expect_header_next = 1'b1;
                    end
                end
            end
            pixels_left_next = pixels_eff - CW'(rep);
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            packet_left_reg   <= '0;
            byte_position_reg <= '0;
            texel_gather_reg  <= '0;
            pixels_left_reg   <= '0;
        end
        else if (fire)
        begin
            expect_header_reg <= expect_header_next;
            packet_is_run_reg <= packet_is_run_next;
            packet_left_reg   <= packet_left_next;
            byte_position_reg <= byte_position_next;
            texel_gather_reg  <= texel_gather_next;
            pixels_left_reg   <= pixels_left_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_pixel_reg  <= gathered;
            out_repeat_reg <= rep;
            out_end_reg    <= (pixels_left_next == '0);
            out_over_reg   <= over;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_repeat_reg, out_pixel_reg};
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_over_reg;

endmodule

// ===== sv/tga_rle_chk.sv =====
`timescale 1ns / 1ps

module tga_rle_chk
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tga_rle_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                               m_tlast,
    input logic                               m_tuser
);

    localparam int PW = tga_rle_pkg::PIXEL_W;
    localparam int RW = tga_rle_pkg::REPEAT_W;

    // a stalled item holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result item changed");

    // repeat count stays within one packet
    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[PW+RW-1:PW] != '0
            && m_tdata[PW+RW-1:PW] <= tga_rle_pkg::REPEAT_MAX)
        else $error("repeat count out of range");

    // a clamped packet always completes the image
    a_overrun_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("overrun without image end");

endmodule

bind tga_rle_pixel_decoder_unit tga_rle_chk u_tga_rle_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int BW   = tga_rle_pkg::BYTE_W;
    localparam int PXW  = tga_rle_pkg::PIXEL_W;
    localparam int RPW  = tga_rle_pkg::REPEAT_W;
    localparam int CNTW = tga_rle_pkg::COUNT_W;
    localparam int MW   = tga_rle_pkg::M_DATA_W;
    localparam int AW   = tga_rle_pkg::CFG_ADDR_W;
    localparam int DW   = tga_rle_pkg::CFG_DATA_W;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic [PXW-1:0] pixel;
        logic [RPW-1:0] run_len;
        logic           image_end;
        logic           overrun;
    } pixel_run_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cfg_we    = 1'b0;
    logic [AW-1:0] cfg_addr  = '0;
    logic [DW-1:0] cfg_wdata = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [BW-1:0] s_tdata   = '0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [MW-1:0] m_tdata;
    logic          m_tlast;
    logic          m_tuser;

    // register copies seen by the predictor
    logic [2:0]      mdl_texel      = tga_rle_pkg::TEXEL_BYTES_BGRA;
    logic            mdl_compressed = 1'b1;
    logic [CNTW-1:0] mdl_pixels     = CNTW'(1);

    // decoder state of the predictor
    logic            need_header = 1'b1;
    logic            pkt_is_run  = 1'b0;
    logic [7:0]      pkt_left    = '0;
    logic [1:0]      gather_pos  = '0;
    logic [31:0]     gather_word = '0;
    logic [CNTW-1:0] px_left     = '0;

    logic [BW-1:0] body_bytes [$];
    pixel_run_t    pending_pixels [$];
    int            bytes_queued = 0;
    int            bytes_taken  = 0;
    int            mismatches   = 0;
    int            quiet_cycles = 0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int tx_gap = 0;
    int rx_gap = 0;
    int rx_hold_seq  = 0;
    int rx_hold_seen = 0;

    tga_rle_pixel_decoder_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // in_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // pixel_value, repeat_count
        .m_tlast   (m_tlast),   // image_end
        .m_tuser   (m_tuser)    // overrun
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 19) < 16)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // expected results of one accepted body byte
    task automatic decode_body_byte(input logic [7:0] b);
        int unsigned tsize;
        int unsigned run_len;
        logic        overrun_bit;
        logic [31:0] value;
        pixel_run_t  res;
        tsize = (mdl_texel == tga_rle_pkg::TEXEL_BYTES_BGRA) ? 4 : 3;
        run_len = 1;
        overrun_bit = 1'b0;

        // packet header, no result
        if (mdl_compressed && need_header)
        begin
            pkt_left    = 8'(b & tga_rle_pkg::HDR_COUNT_MASK) + 8'd1;
            pkt_is_run  = (b & tga_rle_pkg::HDR_RUN_MASK) != 0;
            need_header = 1'b0;
            gather_pos  = '0;
            gather_word = '0;
            return;
        end

        // gather texel bytes, lowest first
        gather_word = gather_word | (32'(b) << (8 * gather_pos));
        if (int'(gather_pos) + 1 < tsize)
        begin
            gather_pos = gather_pos + 2'd1;
            return;
        end
        value = gather_word;
        gather_pos = '0;
        gather_word = '0;

        // new image starts, zero size counts as one pixel
        if (px_left == 0)
            px_left = (mdl_pixels == 0) ? CNTW'(1) : mdl_pixels;

        if (mdl_compressed)
        begin
            if (pkt_is_run)
            begin
                run_len = 32'(pkt_left);
                if (run_len > 32'(px_left))
                begin
                    run_len = 32'(px_left);
                    overrun_bit = 1'b1;
                end
                pkt_left = '0;
                need_header = 1'b1;
            end
            else
            begin
                pkt_left = pkt_left - 8'd1;
                if (pkt_left == 0)
                    need_header = 1'b1;
                // image done with raw texels still to come
                if (px_left == 1 && pkt_left != 0)
                begin
                    overrun_bit = 1'b1;
                    pkt_left = '0;
                    need_header = 1'b1;
                end
            end
        end

        px_left = px_left - CNTW'(run_len);
        res.pixel     = value;
        res.run_len   = RPW'(run_len);
        res.image_end = (px_left == 0);
        res.overrun   = overrun_bit;
        pending_pixels.push_back(res);
    endtask

    task automatic flag_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        body_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic write_reg(input tga_rle_pkg::cfg_index_t idx, input logic [DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            tga_rle_pkg::CFG_TEXEL_BYTES:     mdl_texel      = val[2:0];
            tga_rle_pkg::CFG_COMPRESSED_MODE: mdl_compressed = val[0];
            tga_rle_pkg::CFG_IMAGE_PIXELS:    mdl_pixels     = val[CNTW-1:0];
            default:                          ;
        endcase
        @(posedge clk);
    endtask

    // all bytes taken, all results seen, then let the pipe settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_taken != bytes_queued || pending_pixels.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // packets with random content, plus stray bytes and cut packets
    task automatic fill_phase(input int target);
        int       made;
        int       count;
        int       len;
        int       tsize;
        int       r;
        bit       is_run;
        logic [7:0] hdr;
        tsize = (mdl_texel == tga_rle_pkg::TEXEL_BYTES_BGRA) ? 4 : 3;
        made = 0;
        while (made < target)
        begin
            if (!mdl_compressed || $urandom_range(0, 9) == 0)
            begin
                push_byte(8'($urandom_range(0, 255)));
                made++;
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    count = $urandom_range(1, 6);
                else if (r < 9)
                    count = $urandom_range(7, 32);
                else
                    count = $urandom_range(33, 128);
                is_run = 1'($urandom_range(0, 1));
                hdr = {is_run, 7'(count - 1)};
                len = is_run ? tsize : count * tsize;
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(0, len - 1);
                push_byte(hdr);
                made++;
                repeat (len)
                begin
                    push_byte(8'($urandom_range(0, 255)));
                    made++;
                end
            end
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (body_bytes.size() > 0)
            begin
                s_tdata  <= body_bytes.pop_front();
                s_tvalid <= 1'b1;
                if (tx_idle_on && $urandom_range(0, 3) == 0)
                    tx_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end
        else if (rx_hold_seq != rx_hold_seen)
        begin
            rx_hold_seen = rx_hold_seq;
            rx_gap = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_gap = pick_gap();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: check results first, then predict from the accepted byte
    always @(posedge clk)
    begin
        pixel_run_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual pixel %0h repeat %0d",
                             $time, m_tdata[PXW-1:0], m_tdata[PXW +: RPW]);
                    mismatches++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    flag_field("pixel_value", want.pixel, m_tdata[PXW-1:0]);
                    flag_field("repeat_count", 32'(want.run_len), 32'(m_tdata[PXW +: RPW]));
                    flag_field("image_end", 32'(want.image_end), 32'(m_tlast));
                    flag_field("overrun", 32'(want.overrun), 32'(m_tuser));
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_body_byte(s_tdata);
                bytes_taken++;
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tga_rle_pixel_decoder_unit verification failed");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        logic [7:0] opening [$];
        logic [2:0] texel_sel;
        logic [DW-1:0] pixel_sel;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: run, run past the image end, raw, raw past the image end
        write_reg(tga_rle_pkg::CFG_TEXEL_BYTES, DW'(3));
        write_reg(tga_rle_pkg::CFG_COMPRESSED_MODE, DW'(1));
        write_reg(tga_rle_pkg::CFG_IMAGE_PIXELS, DW'(5));
        cfg_we <= 1'b0;
        @(negedge clk);
        opening = '{8'h80, 8'h00, 8'h00, 8'h00,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h02, 8'h12, 8'h34, 8'h56, 8'hAB, 8'hCD, 8'hEF, 8'h01, 8'h02, 8'h03,
                    8'h7F, 8'h0F, 8'h1E, 8'h2D, 8'h3C, 8'h4B, 8'h5A};
        foreach (opening[i])
            push_byte(opening[i]);
        wait_drained();

        // texel size drops from four to three with three bytes gathered
        write_reg(tga_rle_pkg::CFG_TEXEL_BYTES, DW'(4));
        write_reg(tga_rle_pkg::CFG_COMPRESSED_MODE, DW'(0));
        cfg_we <= 1'b0;
        @(negedge clk);
        repeat (3) push_byte(8'hFF);
        wait_drained();
        write_reg(tga_rle_pkg::CFG_TEXEL_BYTES, DW'(3));
        cfg_we <= 1'b0;
        @(negedge clk);
        push_byte(8'hFF);

        // random phases over several settings
        for (int ph = 0; ph < 12; ph++)
        begin
            wait_drained();
            case (ph)
                4:       texel_sel = 3'd0;
                8:       texel_sel = 3'd7;
                9:       texel_sel = 3'd5;
                default: texel_sel = ph[0] ? 3'd3 : 3'd4;
            endcase
            case (ph)
                0:       pixel_sel = DW'(1);
                2:       pixel_sel = DW'(0);
                10:      pixel_sel = '1;
                11:      pixel_sel = DW'(16777216);
                default: pixel_sel = DW'($urandom_range(1, 40));
            endcase
            write_reg(tga_rle_pkg::CFG_TEXEL_BYTES, DW'(texel_sel));
            write_reg(tga_rle_pkg::CFG_COMPRESSED_MODE,
                      (ph == 3 || ph == 7 || ph == 11) ? DW'(0) : DW'(1));
            write_reg(tga_rle_pkg::CFG_IMAGE_PIXELS, pixel_sel);
            cfg_we <= 1'b0;
            tx_idle_on = (ph % 4 != 1);
            rx_idle_on = (ph % 3 != 1);
            @(negedge clk);
            fill_phase($urandom_range(90, 140));
            if (ph == 5)
                rx_hold_seq++;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tga_rle_pixel_decoder_unit verification clean");
        else
            $display("tga_rle_pixel_decoder_unit verification failed");
        $finish;
    end

endmodule
